FILE: sv/fbcc_pkg.sv
package fbcc_pkg;

  // Default and widths of the configuration port.
  localparam int MAX_ROUNDS_DEF = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 64;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_KEY = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IV = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROUNDS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MODE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DIR = 3'd4;

  // Chaining mode codes; the unused code behaves as ECB.
  localparam logic [1:0] MODE_ECB = 2'd0;
  localparam logic [1:0] MODE_CBC = 2'd1;
  localparam logic [1:0] MODE_CFB = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [4:0] ROUNDS_RST = 5'd10;
  localparam logic [1:0] MODE_RST = MODE_CBC;

  // Key schedule step: round key rotation grows by three bits, or shrinks to decrypt.
  localparam int KEY_STEP = 3;
  localparam int SHAMT_W = 6;

  // Microprogram addresses.
  typedef logic [1:0] step_t;
  localparam step_t STEP_IDLE = 2'd0;
  localparam step_t STEP_PREP = 2'd1;
  localparam step_t STEP_ROUND = 2'd2;
  localparam step_t STEP_FINISH = 2'd3;

  // Branch conditions of a control word.
  typedef enum logic [2:0] {
    COND_ALWAYS,
    COND_IN_FIRE,
    COND_NO_ROUNDS,
    COND_LAST_ROUND,
    COND_OUT_FREE
  } cond_t;

  // One control word of the microprogram.
  typedef struct packed {
    logic  wait_in;
    logic  prep;
    logic  round;
    logic  finish;
    cond_t cond;
    step_t tgt_true;
    step_t tgt_false;
  } ctrl_t;

  // Datapath status that the sequencer branches on.
  typedef struct packed {
    logic in_fire;
    logic no_rounds;
    logic last_round;
    logic out_free;
  } status_t;

  // Control store: wait for a word, load the halves, run the rounds, deliver.
  function automatic ctrl_t ucode_rom(input step_t addr);
    ctrl_t w;
    w = '{wait_in: 1'b0, prep: 1'b0, round: 1'b0, finish: 1'b0,
          cond: COND_ALWAYS, tgt_true: STEP_IDLE, tgt_false: STEP_IDLE};
    case (addr)
      STEP_IDLE: begin
        w.wait_in = 1'b1;
        w.cond = COND_IN_FIRE;
        w.tgt_true = STEP_PREP;
        w.tgt_false = STEP_IDLE;
      end
      STEP_PREP: begin
        w.prep = 1'b1;
        w.cond = COND_NO_ROUNDS;
        w.tgt_true = STEP_FINISH;
        w.tgt_false = STEP_ROUND;
      end
      STEP_ROUND: begin
        w.round = 1'b1;
        w.cond = COND_LAST_ROUND;
        w.tgt_true = STEP_FINISH;
        w.tgt_false = STEP_ROUND;
      end
      STEP_FINISH: begin
        w.finish = 1'b1;
        w.cond = COND_OUT_FREE;
        w.tgt_true = STEP_IDLE;
        w.tgt_false = STEP_FINISH;
      end
      default: begin
        w.cond = COND_ALWAYS;
      end
    endcase
    return w;
  endfunction

endpackage

FILE: sv/feistel_block_cipher_chained_core.sv
// Chained 64-bit Feistel cipher core (ECB, CBC or CFB, encrypt or decrypt).
// Input words arrive on in_valid/in_ready with data_in and first_block; a set
// first_block reloads the chaining register from init_vector for that word.
// Results leave on out_valid/out_ready as data_out, one result per input word.
// Configuration is written through cfg_we/cfg_index/cfg_data; the user must do so
// only while the core is idle, which the core does not enforce; index 0 key,
// 1 IV, 2 round count, 3 chain mode, 4 direction. A small microprogram steps the
// core: a step to take the word, a step to load the halves and the first round key,
// a step per round on the shared 32-bit multiplier, and a step to apply chaining
// and fill the output register. The round count is capped at MAX_ROUNDS and is
// ten at reset; with zero rounds the load step goes straight to the final step.
// The core takes a new word only once the previous one has left the final step.
// Reset clears the chaining register and output valid and restores the
// register defaults. A stalled receiver holds the result in the output register;
// the next word is still accepted and processed, and waits in the final step
// until the output register frees.
module feistel_block_cipher_chained_core #(
  parameter int MAX_ROUNDS = fbcc_pkg::MAX_ROUNDS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [fbcc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fbcc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [63:0]                     data_in,
  input  logic                            first_block,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [63:0]                     data_out
);

  localparam int RW = $clog2(MAX_ROUNDS + 1);
  localparam int CW = (RW > 5) ? RW : 5;
  localparam int SW = fbcc_pkg::SHAMT_W;

  // Configuration registers.
  logic [63:0] cipher_key;
  logic [63:0] init_vector;
  logic [4:0]  round_count;
  logic [1:0]  chain_mode;
  logic        direction;

  // Datapath registers.
  logic [63:0]   data_reg;
  logic [63:0]   chain_value;
  logic [31:0]   l_half;
  logic [31:0]   r_half;
  logic [31:0]   rkey;
  logic [SW-1:0] shamt;
  logic [RW-1:0] left;

  fbcc_pkg::ctrl_t   ctrl;
  fbcc_pkg::status_t status;

  logic          in_fire;
  logic          out_free;
  logic [CW-1:0] rounds_cfg;
  logic [RW-1:0] n_eff;
  logic [RW-1:0] n_m1;
  logic          dec_eff;
  logic [SW-1:0] sh_first;
  logic [SW-1:0] sh_sel;
  logic [SW-1:0] sh_step;
  logic [127:0]  key_dbl;
  logic [31:0]   rkey_calc;
  logic [31:0]   key_rot;
  logic [31:0]   prod;
  logic [31:0]   f_out;
  logic [31:0]   r_new;
  logic          last_round;
  logic [63:0]   feistel_in;
  logic [63:0]   blk;
  logic [63:0]   result;
  logic [63:0]   chain_next;

  fbcc_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl)
  );

  assign in_ready = ctrl.wait_in;
  assign in_fire  = in_valid && ctrl.wait_in;
  assign out_free = !out_valid || out_ready;

  // Configuration writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cipher_key  <= '0;
      init_vector <= '0;
      round_count <= fbcc_pkg::ROUNDS_RST;
      chain_mode  <= fbcc_pkg::MODE_RST;
      direction   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        fbcc_pkg::REG_KEY:    cipher_key  <= cfg_data;
        fbcc_pkg::REG_IV:     init_vector <= cfg_data;
        fbcc_pkg::REG_ROUNDS: round_count <= cfg_data[4:0];
        fbcc_pkg::REG_MODE:   chain_mode  <= cfg_data[1:0];
        fbcc_pkg::REG_DIR:    direction   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Effective round count, capped at MAX_ROUNDS.
  assign rounds_cfg = CW'(round_count);
  assign n_eff = (rounds_cfg > CW'(MAX_ROUNDS)) ? RW'(MAX_ROUNDS) : RW'(rounds_cfg);
  assign n_m1  = n_eff - RW'(1);

  // CFB always runs the cipher forward; decryption walks the keys backwards.
  assign dec_eff = direction && (chain_mode != fbcc_pkg::MODE_CFB);

  // Key rotation amount: 0 upward for encryption, 3*(n-1) downward for decryption.
  assign sh_first = dec_eff ? SW'({2'b00, n_m1} + {1'b0, n_m1, 1'b0}) : '0;
  assign sh_sel   = ctrl.prep ? sh_first : shamt;
  assign sh_step  = dec_eff ? sh_sel - SW'(fbcc_pkg::KEY_STEP)
                            : sh_sel + SW'(fbcc_pkg::KEY_STEP);
  assign key_dbl   = {cipher_key, cipher_key} >> sh_sel;
  assign rkey_calc = key_dbl[31:0];

  // Round function: rotl(L,9) xor not(rotr(k,11) * L).
  assign key_rot    = {rkey[10:0], rkey[31:11]};
  assign prod       = key_rot * l_half;
  assign f_out      = {l_half[22:0], l_half[31:23]} ^ ~prod;
  assign r_new      = r_half ^ f_out;
  assign last_round = (left == RW'(1));

  // Cipher input for the selected chaining mode.
  always_comb begin
    case (chain_mode)
      fbcc_pkg::MODE_CBC: feistel_in = direction ? data_reg : (data_reg ^ chain_value);
      fbcc_pkg::MODE_CFB: feistel_in = chain_value;
      default:            feistel_in = data_reg;
    endcase
  end

  // Chaining applied to the cipher output.
  assign blk = {l_half, r_half};
  always_comb begin
    case (chain_mode)
      fbcc_pkg::MODE_CBC: begin
        result     = direction ? (blk ^ chain_value) : blk;
        chain_next = direction ? data_reg : blk;
      end
      fbcc_pkg::MODE_CFB: begin
        result     = data_reg ^ blk;
        chain_next = direction ? data_reg : (data_reg ^ blk);
      end
      default: begin
        result     = blk;
        chain_next = chain_value;
      end
    endcase
  end

  assign status = '{in_fire: in_fire, no_rounds: (n_eff == '0),
                    last_round: last_round, out_free: out_free};

  // Datapath registers driven by the control word.
  always_ff @(posedge clk) begin
    if (ctrl.wait_in && in_fire) begin
      data_reg <= data_in;
    end
    if (ctrl.prep) begin
      l_half <= feistel_in[63:32];
      r_half <= feistel_in[31:0];
      rkey   <= rkey_calc;
      shamt  <= sh_step;
      left   <= n_eff;
    end
    if (ctrl.round) begin
      if (last_round) begin
        r_half <= r_new;
      end else begin
        l_half <= r_new;
        r_half <= l_half;
      end
      rkey  <= rkey_calc;
      shamt <= sh_step;
      left  <= left - RW'(1);
    end
    if (ctrl.finish && out_free) begin
      data_out <= result;
    end
  end

  // Chaining register: reloaded from the IV on a first word, updated at the end.
  always_ff @(posedge clk) begin
    if (rst) begin
      chain_value <= '0;
    end else if (ctrl.wait_in && in_fire && first_block) begin
      chain_value <= init_vector;
    end else if (ctrl.finish && out_free) begin
      chain_value <= chain_next;
    end
  end

  // Output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.finish && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

FILE: sv/fbcc_seq.sv
module fbcc_seq (
  input  logic              clk,
  input  logic              rst,
  input  fbcc_pkg::status_t status,
  output fbcc_pkg::ctrl_t   ctrl
);

  fbcc_pkg::step_t step;
  fbcc_pkg::step_t step_next;
  logic            taken;

  // The control word for the current step comes straight from the control store.
  assign ctrl = fbcc_pkg::ucode_rom(step);

  // Evaluate the branch condition and pick the next step.
  always_comb begin
    case (ctrl.cond)
      fbcc_pkg::COND_ALWAYS:     taken = 1'b1;
      fbcc_pkg::COND_IN_FIRE:    taken = status.in_fire;
      fbcc_pkg::COND_NO_ROUNDS:  taken = status.no_rounds;
      fbcc_pkg::COND_LAST_ROUND: taken = status.last_round;
      fbcc_pkg::COND_OUT_FREE:   taken = status.out_free;
      default:                   taken = 1'b1;
    endcase
    step_next = taken ? ctrl.tgt_true : ctrl.tgt_false;
  end

  // Step counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= fbcc_pkg::STEP_IDLE;
    end else begin
      step <= step_next;
    end
  end

endmodule

FILE: sv/fbcc_checker.sv
module fbcc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] data_out
);

  // After reset the core is empty and ready for a word.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid && in_ready)
    else $error("core not empty and ready after reset");

  // A word is worked on alone: no second word is taken right after one.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("word accepted while the previous one is in work");

  // A result never appears in the cycle right after a word is taken.
  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !$rose(out_valid))
    else $error("result appeared too early after acceptance");

  // A stalled result holds its word.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(data_out))
    else $error("stalled result word changed or dropped");

endmodule

bind feistel_block_cipher_chained_core fbcc_checker u_fbcc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .data_out  (data_out)
);
